// ----- sv/yccrgb_pkg.sv -----
// Package: shared types, coefficient constants and chroma lookup tables for the YCbCr to RGB converter.
`timescale 1ns / 1ps

package yccrgb_pkg;

   // Single-precision emulation limits (24-bit significand)
   localparam logic [63:0] SIG_TOP = 64'd1 << 24;
   localparam logic [63:0] SIG_LOW = 64'd1 << 23;

   // Coefficients (c/2)*64 + 0.5 as significand * 2^exp.
   // The significand of c is rounded to nearest at 24 bits; adding 0.5 stays exact
   // because it is a multiple of one ulp and the sum stays in the same binade.
   localparam logic [63:0] CB_B_SIG =
      (64'd1772 * (64'd1 << 24) + 64'd1000) / 64'd2000 + (64'd1 << 17);
   localparam int          CB_B_EXP = -18;
   localparam logic [63:0] CR_R_SIG =
      (64'd1402 * (64'd1 << 24) + 64'd1000) / 64'd2000 + (64'd1 << 17);
   localparam int          CR_R_EXP = -18;
   localparam logic [63:0] CB_G_SIG =
      (64'd34414 * (64'd1 << 26) + 64'd100000) / 64'd200000 + (64'd1 << 19);
   localparam int          CB_G_EXP = -20;
   localparam logic [63:0] CR_G_SIG =
      (64'd71414 * (64'd1 << 25) + 64'd100000) / 64'd200000 + (64'd1 << 18);
   localparam int          CR_G_EXP = -19;

   // Widths of the datapath
   localparam int TERM_W  = 16;   // signed chroma contribution, units of 1/64
   localparam int LUMA_W  = 14;   // Y*64 + Y/4
   localparam int SUM_W   = 17;   // signed channel sum
   localparam int ALPHA_W = 8;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef logic [255:0][TERM_W-1:0] table_type;

   // Emulated float value: magnitude and binary exponent
   typedef struct packed {
      logic [63:0]        mag;
      logic signed [31:0] e;
   } sf_type;

   // Stage data between lookup and mixing
   typedef struct packed {
      logic                     valid;
      logic [LUMA_W-1:0]        luma_term;
      logic signed [TERM_W-1:0] cr_red;
      logic signed [TERM_W-1:0] cb_green;
      logic signed [TERM_W-1:0] cr_green;
      logic signed [TERM_W-1:0] cb_blue;
   } terms_type;

   // Round a magnitude to a 24-bit significand, nearest with ties to even
   function automatic sf_type sf_norm(input logic [63:0] mag, input int e);
      sf_type      r;
      int          s;
      int          i;
      int          ee;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      s  = 0;
      ee = e;
      q  = mag;
      if (mag == 64'd0) begin
         r.mag = 64'd0;
         r.e   = 32'sd0;
      end else if (mag >= SIG_TOP) begin
         for (i = 0; i < 40; i = i + 1) begin
            if ((mag >> s) >= SIG_TOP) begin
               s = s + 1;
            end
         end
         q    = mag >> s;
         rem  = mag & ((64'd1 << s) - 64'd1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
         if (q >= SIG_TOP) begin
            q = q >> 1;
            s = s + 1;
         end
         r.mag = q;
         r.e   = ee + s;
      end else begin
         for (i = 0; i < 24; i = i + 1) begin
            if (q < SIG_LOW) begin
               q  = q << 1;
               ee = ee - 1;
            end
         end
         r.mag = q;
         r.e   = ee;
      end
      return r;
   endfunction

   // One chroma entry: trunc(coef * (2*sample - 255) [+ 32]) in single precision
   function automatic logic signed [TERM_W-1:0] chroma_entry(
      input logic [63:0] sig, input int e, input bit negate, input bit bias,
      input int sample);
      int          x;
      int          ax;
      int          emin;
      bit          neg;
      sf_type      p;
      longint      sa;
      longint      sb;
      longint      sum;
      logic [63:0] mag;
      logic [63:0] v;
      x   = 2 * sample - 255;
      ax  = (x < 0) ? -x : x;
      neg = negate ^ (x < 0);
      p   = sf_norm(sig * 64'(ax), e);
      if (bias) begin
         emin = (p.e < -18) ? int'(p.e) : -18;
         sa   = longint'(p.mag << (p.e - emin));
         if (neg) begin
            sa = -sa;
         end
         sb   = longint'(SIG_LOW << (-18 - emin));
         sum  = sa + sb;
         neg  = (sum < 0);
         mag  = (sum < 0) ? 64'(-sum) : 64'(sum);
         p    = sf_norm(mag, emin);
      end
      if (p.e >= 0) begin
         v = p.mag << p.e;
      end else begin
         v = p.mag >> (-p.e);
      end
      if (neg) begin
         v = -v;
      end
      return v[TERM_W-1:0];
   endfunction

   // Build a 256-entry table for one coefficient
   function automatic table_type build_table(
      input logic [63:0] sig, input int e, input bit negate, input bit bias);
      table_type t;
      int        k;
      for (k = 0; k < 256; k = k + 1) begin
         t[k] = chroma_entry(sig, e, negate, bias, k);
      end
      return t;
   endfunction

   localparam table_type CB_B_TABLE = build_table(CB_B_SIG, CB_B_EXP, 1'b0, 1'b1);
   localparam table_type CR_R_TABLE = build_table(CR_R_SIG, CR_R_EXP, 1'b0, 1'b1);
   localparam table_type CB_G_TABLE = build_table(CB_G_SIG, CB_G_EXP, 1'b1, 1'b0);
   localparam table_type CR_G_TABLE = build_table(CR_G_SIG, CR_G_EXP, 1'b1, 1'b1);

endpackage

// ----- sv/ycbcr_to_rgb_pixel_converter_unit.sv -----
// Top level of the full-range BT.601 YCbCr to RGB pixel converter.
`timescale 1ns / 1ps

// Converts one pixel per clock. A transfer is taken when start is high and busy is
// low; busy is always low, so a pixel may be offered on every cycle. Each pixel
// passes through the input register, table read, channel sum and clamp and pack
// stages and comes out on rsp_pixel_word with rsp_valid high for exactly one
// cycle. The receiver cannot stall, so it must take every result in the cycle it is
// shown. The word holds red in 7:0, green in 15:8, blue in 23:16 and 0xFF in 31:24.
module ycbcr_to_rgb_pixel_converter_unit
   import yccrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_luma,
   input  logic [7:0]  req_chroma_blue,
   input  logic [7:0]  req_chroma_red,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel_word
);

   logic      req_accept;
   terms_type lookup_terms;

   // No back-pressure anywhere in the pipeline
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   yccrgb_lookup u_lookup (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .luma        (req_luma),
      .chroma_blue (req_chroma_blue),
      .chroma_red  (req_chroma_red),
      .terms       (lookup_terms)
   );

   yccrgb_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .terms      (lookup_terms),
      .out_valid  (rsp_valid),
      .pixel_word (rsp_pixel_word)
   );

`ifndef ASSERT_OFF
   // Every transfer yields a result
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##4 rsp_valid)
      else $error("accepted pixel produced no result");

   // No result without a matching earlier transfer
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |-> ##4 !rsp_valid)
      else $error("result without a matching transfer");

   // Lookup stage valid follows the transfer through the input and lookup registers
   assert property (@(posedge clock) disable iff (reset)
      lookup_terms.valid |-> $past(req_accept, 2))
      else $error("lookup stage valid out of step");

   // Alpha byte is opaque on every result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_word[31:24] == ALPHA_OPAQUE)
      else $error("alpha byte not opaque");
`endif

endmodule

// ----- sv/yccrgb_lookup.sv -----
// Input register and table lookup stages of the YCbCr to RGB converter.
`timescale 1ns / 1ps

module yccrgb_lookup
   import yccrgb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] luma,
   input  logic [7:0] chroma_blue,
   input  logic [7:0] chroma_red,
   output terms_type  terms
);

   logic       valid_ff;
   logic [7:0] luma_ff;
   logic [7:0] cb_ff;
   logic [7:0] cr_ff;
   terms_type  terms_in;
   terms_type  terms_ff;

   // Stage 1: capture the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      luma_ff <= luma;
      cb_ff   <= chroma_blue;
      cr_ff   <= chroma_red;
   end

   // Stage 2: luma term and the four chroma table reads
   always_comb begin
      terms_in.valid     = valid_ff;
      terms_in.luma_term = {luma_ff, luma_ff[7:2]};
      terms_in.cr_red    = CR_R_TABLE[cr_ff];
      terms_in.cb_green  = CB_G_TABLE[cb_ff];
      terms_in.cr_green  = CR_G_TABLE[cr_ff];
      terms_in.cb_blue   = CB_B_TABLE[cb_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff.valid <= 1'b0;
      end else begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

// ----- sv/yccrgb_mix.sv -----
// Channel sum, clamp and pack stages of the YCbCr to RGB converter.
`timescale 1ns / 1ps

module yccrgb_mix
   import yccrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  terms_type   terms,
   output logic        out_valid,
   output logic [31:0] pixel_word
);

   logic                    sum_valid_ff;
   logic signed [SUM_W-1:0] red_ff;
   logic signed [SUM_W-1:0] green_ff;
   logic signed [SUM_W-1:0] blue_ff;
   logic signed [SUM_W-1:0] red_in;
   logic signed [SUM_W-1:0] green_in;
   logic signed [SUM_W-1:0] blue_in;
   logic signed [SUM_W-1:0] luma_ext;
   logic                    out_valid_ff;
   logic [31:0]             pixel_ff;
   logic [31:0]             pixel_in;

   // Clamp a signed sum to 0..255 after dropping the six fraction bits
   function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
      logic [7:0] c;
      if (sum[SUM_W-1]) begin
         c = 8'd0;
      end else if (sum[SUM_W-2:14] != '0) begin
         c = 8'd255;
      end else begin
         c = sum[13:6];
      end
      return c;
   endfunction

   // Stage 3: per-channel sums
   assign luma_ext = $signed({{(SUM_W-LUMA_W){1'b0}}, terms.luma_term});
   assign red_in   = luma_ext + SUM_W'(terms.cr_red);
   assign green_in = luma_ext + SUM_W'(terms.cb_green) + SUM_W'(terms.cr_green);
   assign blue_in  = luma_ext + SUM_W'(terms.cb_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= terms.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   // Stage 4: clamp and pack into the result register
   assign pixel_in = {ALPHA_OPAQUE, clamp_channel(blue_ff), clamp_channel(green_ff),
                      clamp_channel(red_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sum_valid_ff;
      end
      pixel_ff <= pixel_in;
   end

   assign out_valid  = out_valid_ff;
   assign pixel_word = pixel_ff;

endmodule
